/* rtl/slgc_pkg.sv */
// ============================================================================
// slgc_pkg: shared types and constants of the glyph cache tag store
// Holds the transaction payload types, the tag entry layout, the hash
// multiplier and the result status codes.
// ============================================================================
package slgc_pkg;

    // Default geometry.
    localparam int NUM_WAYS_DEF = 4;
    localparam int MAX_SETS_DEF = 64;

    // Field widths.
    localparam int KEY_W       = 26;
    localparam int CODE_W      = 24;
    localparam int STYLE_W     = 2;
    localparam int STAMP_W     = 32;
    localparam int SET_COUNT_W = 7;
    localparam int SLOT_W      = 8;
    localparam int HASH_W      = 32;

    // Multiplicative hash constant.
    localparam logic [HASH_W-1:0] HASH_MUL = 32'd2654435761;

    // Request kinds.
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_FILLED = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;

    // Request payload.
    typedef struct packed {
        logic               kind;
        logic [STYLE_W-1:0] style;
        logic [CODE_W-1:0]  codepoint;
        logic               fill_ok;
    } t_in_item;

    // Result payload.
    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } t_out_item;

    // One way of a set as held in the tag memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

/* rtl/slgc_row_ram.sv */
// ============================================================================
// slgc_row_ram: tag memory, one row per set
// Simple dual-port synchronous RAM with one write port and one read port;
// read data is registered and appears in the cycle after the read enable.
// ============================================================================
module slgc_row_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 232
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/slgc_set_div.sv */
// ============================================================================
// slgc_set_div: set index computation
// Hashes the key with one 32-bit multiply, then reduces the product modulo
// the set count by restoring division, one quotient bit per cycle.
// ============================================================================
module slgc_set_div #(
    parameter int SET_W = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [slgc_pkg::KEY_W-1:0]       i_key,
    input  logic [slgc_pkg::SET_COUNT_W-1:0] i_sets,
    output logic                             o_done,
    output logic [SET_W-1:0]                 o_set
);
    import slgc_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [HASH_W-1:0]      r_prod;
    logic [SET_COUNT_W-1:0] r_rem;
    logic [SET_COUNT_W-1:0] r_sets;
    logic [SET_COUNT_W:0]   trial;
    logic [SET_COUNT_W-1:0] n_rem;

    // One restoring step: shift in the next product bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_prod[HASH_W-1]};
        if (trial >= {1'b0, r_sets}) begin
            n_rem = SET_COUNT_W'(trial - {1'b0, r_sets});
        end else begin
            n_rem = trial[SET_COUNT_W-1:0];
        end
    end

    // Control: start loads the hashed key, then one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: product and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= HASH_MUL * {{(HASH_W - KEY_W){1'b0}}, i_key};
            r_sets <= i_sets;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_prod <= {r_prod[HASH_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_set  = SET_W'(r_rem);

endmodule

/* rtl/set_assoc_lru_glyph_cache.sv */
// ============================================================================
// set_assoc_lru_glyph_cache: LRU tag store of a set-associative glyph cache
// Looks up a (style, code point) key, picks a replacement way on a miss and
// records the outcome of the external fill.
// ============================================================================
// Usage:
//   Requests arrive on i_in_valid/o_in_ready/i_in_data, results leave on
//   o_out_valid/i_out_ready/o_out_data; every request transaction yields
//   exactly one result transaction, in order. i_cfg_we/i_cfg_wdata write the
//   set count; write it only while no request is in flight.
//   One request is handled at a time. A lookup first passes through the serial
//   modulo unit that maps the hashed key to a set, then reads the set's row
//   from the tag memory and scans its ways one per cycle on a miss. A request
//   with set count zero or key zero answers without a lookup. A flush rewrites
//   every row, one per cycle, and then answers. After reset the same clearing
//   pass runs, during which o_in_ready stays low; configuration writes are
//   taken throughout.
//   The result sits in an output register; if the receiver stalls, the block
//   holds the finished result there and the next request can be taken and
//   worked on, waiting only before it would overwrite the held result.
// ============================================================================
module set_assoc_lru_glyph_cache #(
    parameter int NUM_WAYS = slgc_pkg::NUM_WAYS_DEF,
    parameter int MAX_SETS = slgc_pkg::MAX_SETS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  slgc_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output slgc_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [slgc_pkg::SET_COUNT_W-1:0] i_cfg_wdata
);
    import slgc_pkg::*;

    localparam int AW      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W   = NUM_WAYS * $bits(t_entry);
    localparam int CAP_INT = (MAX_SETS < 127) ? MAX_SETS : 127;
    localparam logic [SET_COUNT_W-1:0] SET_CAP = SET_COUNT_W'(CAP_INT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_LOOK,
        S_SCAN,
        S_WRITE,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [SET_COUNT_W-1:0]  r_set_count;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_flush;
    logic [STAMP_W-1:0]      r_use;
    logic [KEY_W-1:0]        r_key;
    logic                    r_fill_ok;
    logic [AW-1:0]           r_set;
    t_entry [NUM_WAYS-1:0]   r_row;
    logic                    r_hit;
    logic [WW-1:0]           r_way;
    logic [WW-1:0]           r_scan_way;
    logic [STAMP_W-1:0]      r_oldest;
    t_out_item               r_res;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    in_acc;
    logic [SET_COUNT_W-1:0]  eff_sets;
    logic [KEY_W-1:0]        in_key;
    logic                    div_start;
    logic                    div_done;
    logic [AW-1:0]           div_set;
    t_entry [NUM_WAYS-1:0]   rd_row;
    logic                    look_hit;
    logic [WW-1:0]           look_way;
    t_entry                  scan_ent;
    t_entry [NUM_WAYS-1:0]   n_row;
    logic [STAMP_W-1:0]      n_use;
    logic [SLOT_W-1:0]       n_slot;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [ROW_W-1:0]        ram_wdata;

    // Handshake and request decode.
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_key     = {i_in_data.style, i_in_data.codepoint};
    assign eff_sets   = (r_set_count > SET_CAP) ? SET_CAP : r_set_count;
    assign div_start  = in_acc && (i_in_data.kind == KIND_LOOKUP)
                        && (eff_sets != '0) && (in_key != '0);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_count <= '0;
        end else if (i_cfg_we) begin
            r_set_count <= i_cfg_wdata;
        end
    end

    // Set index unit.
    slgc_set_div #(
        .SET_W (AW)
    ) u_set_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_key   (in_key),
        .i_sets  (eff_sets),
        .o_done  (div_done),
        .o_set   (div_set)
    );

    // Tag memory: clearing pass or read-modify-write of one row.
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_set;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : ROW_W'(n_row);

    slgc_row_ram #(
        .DEPTH (MAX_SETS),
        .AW    (AW),
        .DW    (ROW_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (div_done),
        .i_raddr (div_set),
        .o_rdata (rd_row)
    );

    // Hit detection over the ways of the row just read; first match wins.
    always_comb begin
        look_hit = 1'b0;
        look_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!look_hit && (rd_row[w].key == r_key)) begin
                look_hit = 1'b1;
                look_way = WW'(w);
            end
        end
    end

    assign scan_ent = r_row[r_scan_way];

    // Row update, use counter and result for the chosen way.
    always_comb begin
        n_row  = r_row;
        n_use  = r_use + 1'b1;
        n_slot = SLOT_W'(32'(r_set) * 32'(NUM_WAYS) + 32'(r_way));
        if (r_hit || r_fill_ok) begin
            n_row[r_way].key   = r_key;
            n_row[r_way].stamp = n_use;
        end else begin
            n_row[r_way].key = '0;
        end
    end

    // Sequencer and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_flush     <= 1'b0;
            r_use       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output state reloads the register itself when it drains.
            if (o_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == AW'(MAX_SETS - 1)) begin
                        r_clr_addr <= '0;
                        if (r_flush) begin
                            r_flush <= 1'b0;
                            r_res   <= '{status: ST_NONE, slot_index: '0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_key     <= in_key;
                        r_fill_ok <= i_in_data.fill_ok;
                        if (i_in_data.kind == KIND_FLUSH) begin
                            r_use   <= '0;
                            r_flush <= 1'b1;
                            r_state <= S_CLEAR;
                        end else if (div_start) begin
                            r_state <= S_DIV;
                        end else begin
                            r_res   <= '{status: ST_NONE, slot_index: '0};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_set   <= div_set;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_row      <= rd_row;
                    r_hit      <= look_hit;
                    r_way      <= look_way;
                    r_scan_way <= '0;
                    r_oldest   <= '1;
                    r_state    <= look_hit ? S_WRITE : S_SCAN;
                end
                S_SCAN: begin
                    // First empty way ends the search; else strictly oldest stamp.
                    if (scan_ent.key == '0) begin
                        r_way   <= r_scan_way;
                        r_state <= S_WRITE;
                    end else begin
                        if (scan_ent.stamp < r_oldest) begin
                            r_oldest <= scan_ent.stamp;
                            r_way    <= r_scan_way;
                        end
                        if (r_scan_way == WW'(NUM_WAYS - 1)) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_scan_way <= r_scan_way + 1'b1;
                        end
                    end
                end
                S_WRITE: begin
                    if (r_hit) begin
                        r_use <= n_use;
                        r_res <= '{status: ST_HIT, slot_index: n_slot};
                    end else if (r_fill_ok) begin
                        r_use <= n_use;
                        r_res <= '{status: ST_FILLED, slot_index: n_slot};
                    end else begin
                        r_res <= '{status: ST_NONE, slot_index: '0};
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result without a glyph never points at a slot.
    a_none_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_NONE)) |-> (o_out_data.slot_index == '0))
        else $error("no-glyph result carries a nonzero slot index");

    // Only the three defined status codes are ever produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == ST_HIT) || (o_out_data.status == ST_FILLED)
                         || (o_out_data.status == ST_NONE)))
        else $error("result status code out of range");

    // The set index from the modulo unit lies below the active set count.
    a_set_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (32'(div_set) < 32'(eff_sets)))
        else $error("set index not below set count");

    // One request at a time: an accepted request blocks the input next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted while a request is in flight");

endmodule
